@@ hw/rtl/bsd_pkg.sv @@
// bsd_pkg: shared constants, types and the alphabet lookup of the base64 stream decoder.
// Depends on nothing; used by base64_stream_decoder and tb_top.
`default_nettype none

package bsd_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned HeldW  = 3 * SextW;
  localparam int unsigned WordW  = 4 * SextW;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StatW  = 3;
  localparam int unsigned QErrW  = 2;

  localparam logic [SymW-1:0] PAD_CHAR = 8'h3D;

  typedef enum logic [StatW-1:0] {
    ST_DATA     = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_BAD_PAD  = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_END_OK   = 3'd4
  } status_t;

  // Quad error codes use the low bits of the matching status codes.
  localparam logic [QErrW-1:0] QERR_NONE = 2'd0;
  localparam logic [QErrW-1:0] QERR_CHAR = 2'd1;
  localparam logic [QErrW-1:0] QERR_PAD  = 2'd2;

  typedef struct packed {
    logic             ok;
    logic [SextW-1:0] val;
  } sextet_t;

  // Sextet of one character of the standard alphabet; ok is low outside it.
  function automatic sextet_t sextet_of(input logic [SymW-1:0] c);
    sextet_t   r;
    logic [SymW-1:0] t;
    r = '{ok: 1'b0, val: '0};
    t = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r = '{ok: 1'b1, val: t[SextW-1:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      r = '{ok: 1'b1, val: t[SextW-1:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      r = '{ok: 1'b1, val: t[SextW-1:0]};
    end else if (c == 8'h2B) begin
      r = '{ok: 1'b1, val: 6'd62};
    end else if (c == 8'h2F) begin
      r = '{ok: 1'b1, val: 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/base64_stream_decoder.sv @@
// base64_stream_decoder: streaming base64 (standard alphabet) decoder, one character per request.
// Depends on bsd_pkg for constants, the status type and the sextet lookup.
// A quad's results go from the input register through the run register and the output register
// to out_*. Throughput: one character per cycle, unless a result-making request waits for the
// previous run to empty; a quad's bytes leave the run register one per cycle while not stalled.
// Reset (rst_n low, synchronous) empties all stages and clears the quad state.
`default_nettype none

module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic [0:0] in_tuser,   // [0] finish
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] data_byte
  output logic            out_tlast,  // last_of_run
  output logic [2:0]      out_tuser   // [2:0] status
);

  localparam int unsigned SymW  = bsd_pkg::SymW;
  localparam int unsigned SextW = bsd_pkg::SextW;
  localparam int unsigned HeldW = bsd_pkg::HeldW;
  localparam int unsigned WordW = bsd_pkg::WordW;
  localparam int unsigned ByteW = bsd_pkg::ByteW;
  localparam int unsigned QErrW = bsd_pkg::QErrW;

  // ---------------- input register ----------------
  logic            in_v_r;
  logic [SymW-1:0] sym_r;
  logic            fin_r;

  // ---------------- quad state ----------------
  logic [1:0]       pos_r,  pos_nxt;
  logic [HeldW-1:0] held_r, held_nxt;
  logic             pad_r,  pad_nxt;     // '=' ended the quad early
  logic             pad2_r, pad2_nxt;    // that '=' sat in the third position
  logic [QErrW-1:0] qerr_r, qerr_nxt;

  // ---------------- run register: results of one request ----------------
  logic [WordW-1:0]       run_word_r;   // next byte in [23:16]
  logic [1:0]             run_cnt_r;    // results still to hand over
  bsd_pkg::status_t       run_st_r;

  // ---------------- output register ----------------
  logic                   out_v_r;
  logic [ByteW-1:0]       out_data_r;
  logic                   out_last_r;
  bsd_pkg::status_t       out_st_r;

  // ---------------- decode of the held request ----------------
  bsd_pkg::sextet_t sx;
  logic             live;
  logic [SextW-1:0] v;
  logic             need;               // this request makes results
  logic [1:0]       new_cnt;
  logic [WordW-1:0] new_word;
  bsd_pkg::status_t new_st;

  always_comb begin
    sx       = bsd_pkg::sextet_of(sym_r);
    live     = (qerr_r == bsd_pkg::QERR_NONE) && !pad_r;
    v        = '0;
    pad_nxt  = pad_r;
    pad2_nxt = pad2_r;
    qerr_nxt = qerr_r;
    held_nxt = held_r;
    pos_nxt  = pos_r;
    need     = 1'b0;
    new_cnt  = 2'd0;
    new_word = '0;
    new_st   = bsd_pkg::ST_DATA;

    if (live) begin
      if (sym_r == bsd_pkg::PAD_CHAR) begin
        if (pos_r < 2'd2) begin
          qerr_nxt = bsd_pkg::QERR_PAD;
        end else begin
          pad_nxt  = 1'b1;
          pad2_nxt = (pos_r == 2'd2);
        end
      end else if (!sx.ok) begin
        qerr_nxt = bsd_pkg::QERR_CHAR;
      end else begin
        v = sx.val;
      end
    end

    if (fin_r) begin
      // end of message: any partial quad is a length error; pending quad error is dropped
      need     = 1'b1;
      new_cnt  = 2'd1;
      new_st   = (pos_r != 2'd0) ? bsd_pkg::ST_BAD_LEN : bsd_pkg::ST_END_OK;
      pos_nxt  = '0;
      held_nxt = '0;
      pad_nxt  = 1'b0;
      pad2_nxt = 1'b0;
      qerr_nxt = bsd_pkg::QERR_NONE;
    end else if (pos_r != 2'd3) begin
      held_nxt = {held_r[HeldW-SextW-1:0], v};
      pos_nxt  = pos_r + 2'd1;
    end else begin
      need = 1'b1;
      if (qerr_nxt != bsd_pkg::QERR_NONE) begin
        new_cnt = 2'd1;
        new_st  = bsd_pkg::status_t'({1'b0, qerr_nxt});
      end else begin
        new_word = {held_r, v};
        new_cnt  = pad_nxt ? (pad2_nxt ? 2'd1 : 2'd2) : 2'd3;
      end
      pos_nxt  = '0;
      held_nxt = '0;
      pad_nxt  = 1'b0;
      pad2_nxt = 1'b0;
      qerr_nxt = bsd_pkg::QERR_NONE;
    end
  end

  // ---------------- flow control ----------------
  logic move;      // run hands one result to the output register
  logic run_free;  // run is empty after this edge's hand-over
  logic adv;       // held request is consumed

  assign move      = (run_cnt_r != 2'd0) && (!out_v_r || out_tready);
  assign run_free  = (run_cnt_r == 2'd0) || ((run_cnt_r == 2'd1) && move);
  assign adv       = in_v_r && (!need || run_free);
  assign in_tready = !in_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sym_r <= in_tdata;
      fin_r <= in_tuser[0];
    end
  end

  // quad state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      held_r <= '0;
      pad_r  <= 1'b0;
      pad2_r <= 1'b0;
      qerr_r <= bsd_pkg::QERR_NONE;
    end else if (adv) begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      pad_r  <= pad_nxt;
      pad2_r <= pad2_nxt;
      qerr_r <= qerr_nxt;
    end
  end

  // run register: loads a fresh run, else shifts one byte out per hand-over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r  <= '0;
      run_word_r <= '0;
      run_st_r   <= bsd_pkg::ST_DATA;
    end else if (adv && need) begin
      run_cnt_r  <= new_cnt;
      run_word_r <= new_word;
      run_st_r   <= new_st;
    end else if (move) begin
      run_cnt_r  <= run_cnt_r - 2'd1;
      run_word_r <= {run_word_r[WordW-ByteW-1:0], {ByteW{1'b0}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (move) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= run_word_r[WordW-1:WordW-ByteW];
      out_last_r <= (run_cnt_r == 2'd1);
      out_st_r   <= run_st_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_st_r;

  // ---------------- assertions ----------------
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_st_r != bsd_pkg::ST_DATA) |-> (out_data_r == '0) && out_last_r)
    else $error("error or end result carries data or is not last");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    adv && need |-> run_free)
    else $error("run overwritten while results remain");

  a_empty_quad: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == 2'd0 |-> (held_r == '0) && !pad_r && (qerr_r == bsd_pkg::QERR_NONE))
    else $error("quad state not cleared at quad start");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_tready)
    else $error("empty input register refuses requests");

  a_move_data: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_v_r)
    else $error("handed-over result lost");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// tb_top: self-checking bench for base64_stream_decoder; random and directed character streams.
// Depends on bsd_pkg (widths, status codes, pad character) and the decoder RTL only.

module tb_top;

  localparam int unsigned SymW  = bsd_pkg::SymW;
  localparam int unsigned SextW = bsd_pkg::SextW;
  localparam int unsigned HeldW = bsd_pkg::HeldW;
  localparam int unsigned WordW = bsd_pkg::WordW;
  localparam int unsigned ByteW = bsd_pkg::ByteW;
  localparam int unsigned StatW = bsd_pkg::StatW;
  localparam int unsigned QErrW = bsd_pkg::QErrW;

  localparam int unsigned GapMax    = 14;
  localparam int unsigned RandItems = 160;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned DrainWait = 20;
  localparam string       Alphabet  =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic              last;
    bsd_pkg::status_t  st;
  } result_t;

  // Tracks the quad under assembly and the results it owes.
  class quad_decode_sb;
    logic [1:0]       quad_pos;
    logic [HeldW-1:0] held;
    bit               pad_seen;
    logic [1:0]       pad_pos;
    logic [QErrW-1:0] qerr;
    result_t          due[$];
    int               errors;

    function new();
      clear_quad();
      errors = 0;
    endfunction

    function void clear_quad();
      quad_pos = '0;
      held     = '0;
      pad_seen = 1'b0;
      pad_pos  = '0;
      qerr     = bsd_pkg::QERR_NONE;
    endfunction

    // Alphabet position of a character; returns 0 when it is not a base64 character.
    function bit char_value(input logic [SymW-1:0] c, output logic [SextW-1:0] v);
      v = '0;
      if (c >= "A" && c <= "Z") v = SextW'(c - "A");
      else if (c >= "a" && c <= "z") v = SextW'(c - "a" + 26);
      else if (c >= "0" && c <= "9") v = SextW'(c - "0" + 52);
      else if (c == "+") v = 6'd62;
      else if (c == "/") v = 6'd63;
      else return 1'b0;
      return 1'b1;
    endfunction

    function void push(logic [ByteW-1:0] data, logic last, bsd_pkg::status_t st);
      result_t r;
      r.data = data;
      r.last = last;
      r.st   = st;
      due.push_back(r);
    endfunction

    function void note_request(logic [SymW-1:0] sym, logic fin);
      logic [SextW-1:0] v;
      logic [WordW-1:0] word;
      int               n;
      v = '0;
      if (fin) begin
        push('0, 1'b1, (quad_pos != 0) ? bsd_pkg::ST_BAD_LEN : bsd_pkg::ST_END_OK);
        clear_quad();
        return;
      end
      // once the quad is dead or padded, later characters are not looked at
      if (qerr == bsd_pkg::QERR_NONE && !pad_seen) begin
        if (sym == bsd_pkg::PAD_CHAR) begin
          if (quad_pos < 2) qerr = bsd_pkg::QERR_PAD;
          else begin
            pad_seen = 1'b1;
            pad_pos  = quad_pos;
          end
        end else if (!char_value(sym, v)) begin
          qerr = bsd_pkg::QERR_CHAR;
        end
      end
      if (quad_pos != 2'd3) begin
        held     = {held[HeldW-SextW-1:0], v};
        quad_pos = quad_pos + 2'd1;
        return;
      end
      if (qerr != bsd_pkg::QERR_NONE) begin
        push('0, 1'b1, bsd_pkg::status_t'({1'b0, qerr}));
        clear_quad();
        return;
      end
      word = {held, v};
      n = pad_seen ? ((pad_pos == 2'd2) ? 1 : 2) : 3;
      for (int k = 0; k < n; k++)
        push(ByteW'(word >> (16 - 8 * k)), k == n - 1, bsd_pkg::ST_DATA);
      clear_quad();
    endfunction

    function void check_result(logic [ByteW-1:0] data, logic last, logic [StatW-1:0] st);
      result_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got data %02h last %0b status %0d",
                 $time, data, last, st);
        return;
      end
      want = due.pop_front();
      if (data !== want.data) begin
        errors++;
        $display("%0t: data_byte mismatch: expected %02h, got %02h", $time, want.data, data);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_run mismatch: expected %0b, got %0b", $time, want.last, last);
      end
      if (st !== want.st) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.st, st);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [SymW-1:0]  in_tdata   = '0;   // [7:0] symbol
  logic [0:0]       in_tuser   = '0;   // [0] finish
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [ByteW-1:0] out_tdata;         // [7:0] data_byte
  logic             out_tlast;
  logic [StatW-1:0] out_tuser;         // [2:0] status

  quad_decode_sb sb;
  bit            in_quiet  = 1'b0;
  bit            out_quiet = 1'b0;
  int unsigned   sent      = 0;
  int unsigned   idle      = 0;

  base64_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One request; valid stays high across back-to-back requests.
  task automatic send(input logic [SymW-1:0] sym, input logic fin);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, GapMax);
    if ($urandom_range(0, 24) == 0) in_quiet = !in_quiet;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_request(sym, fin);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  function automatic logic [SymW-1:0] b64_char();
    return Alphabet[$urandom_range(0, 63)];
  endfunction

  function automatic logic [SymW-1:0] noisy_char();
    case ($urandom_range(0, 2))
      0:       return SymW'($urandom_range(0, 255));
      1:       return bsd_pkg::PAD_CHAR;
      default: return b64_char();
    endcase
  endfunction

  // Mostly well-formed quads, some padded, some noisy, some cut short, then a finish.
  task automatic send_message();
    int quads;
    int kind;
    int n;
    quads = $urandom_range(0, 4);
    for (int q = 0; q < quads; q++) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        n = $urandom_range(1, 3);
        repeat (n) send(b64_char(), 1'b0);
        break;
      end
      for (int p = 0; p < 4; p++) begin
        if (kind == 8) send(noisy_char(), 1'b0);
        else if (kind == 6 && p == 3) send(bsd_pkg::PAD_CHAR, 1'b0);
        else if (kind == 7 && p == 2) send(bsd_pkg::PAD_CHAR, 1'b0);
        else if (kind == 7 && p == 3)
          send(($urandom_range(0, 3) == 0) ? SymW'($urandom_range(0, 255))
                                           : bsd_pkg::PAD_CHAR, 1'b0);
        else send(b64_char(), 1'b0);
      end
    end
    send(SymW'($urandom_range(0, 255)), 1'b1);
  endtask

  // Result side: random back-pressure per result, with quiet stretches.
  initial begin
    int stall;
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, GapMax);
      if ($urandom_range(0, 24) == 0) out_quiet = !out_quiet;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  // Watchdog: too long without any handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle <= 0;
    else idle <= idle + 1;
    if (idle == IdleLimit) begin
      $display("%0t: no request moved for %0d cycles", $time, IdleLimit);
      $display("[base64_stream_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: plain quad, pad in third place with junk fourth, pad in fourth place
    send_text("TWFu");
    send_text("TQ=!");
    send_text("TWE=");
    // early pad beats the later bad character
    send_text("A=*A");
    // top sextets, then a bad character with every bit set in the last place
    send_text("/+9");
    send(8'hFF, 1'b0);
    // clean finish; its symbol is ignored
    send(8'hA5, 1'b1);
    // pad first, then a zero byte: pending error is swallowed by the short finish
    send(bsd_pkg::PAD_CHAR, 1'b0);
    send(8'h00, 1'b0);
    send(8'h00, 1'b1);

    while (sent < RandItems) send_message();
    in_tvalid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[base64_stream_decoder] OK");
    end else begin
      $display("[base64_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule

@@ base64_stream_decoder.f @@
hw/rtl/bsd_pkg.sv
hw/rtl/base64_stream_decoder.sv
test/tb_top.sv
